[rtl/core/rps_pkg.sv]
`timescale 1ns / 1ps
package rps_pkg;

  // Field widths of the command and response channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned PIXEL_W  = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RST  = 9'd256;

  // Default frame store geometry; sizes compare in the coordinate width
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned SIZE_CMP_W     = POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FILL  = 2'd2
  } rps_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACCESS,
    ST_READ,
    ST_FILL,
    ST_DONE
  } rps_state_e;

  // RGB565 -> RGB332: top 3 red, top 3 green, top 2 blue bits
  function automatic logic [PIXEL_W-1:0] pack332(input logic [COLOR_W-1:0] c);
    return {c[15:13], c[10:8], c[4:3]};
  endfunction

  // RGB332 -> RGB565: low bits of each channel copy the lowest kept bit
  function automatic logic [COLOR_W-1:0] expand565(input logic [PIXEL_W-1:0] p);
    return {p[7:5], {2{p[5]}}, p[4:2], {3{p[2]}}, p[1:0], {3{p[0]}}};
  endfunction

endpackage

[rtl/core/rps_if.sv]
`timescale 1ns / 1ps
interface rps_req_if
  import rps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [COLOR_W-1:0] color_in;

  modport source (output valid, command, pos_x, pos_y, color_in, input ready);
  modport sink   (input valid, command, pos_x, pos_y, color_in, output ready);
endinterface

interface rps_rsp_if
  import rps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_out;
  logic               in_range;

  modport source (output valid, color_out, in_range, input ready);
  modport sink   (input valid, color_out, in_range, output ready);
endinterface

[rtl/core/rgb332_pixel_store.sv]
`timescale 1ns / 1ps
// Frame store of MAX_WIDTH x MAX_HEIGHT pixels, one RGB332 byte each, held in a
// single-port synchronous RAM; pixel (x,y) sits at x + y * width. Commands are
// handled one at a time, each through the states MUL, ACCESS and DONE; a read
// inside the frame also passes READ, and a fill passes FILL, writing width *
// height pixels, one pixel per cycle through the one RAM port. The address
// product goes through one registered multiplier step. A finished response
// waits in an output register, so the next command can be taken while it is
// pending. Width and height must be written only while idle, which the block
// does not enforce; sizes of 0 act as 1 and sizes above the maximum act as the
// maximum. The RAM has no reset and no clearing pass: a pixel reads back as
// garbage until it has been written or filled.
module rgb332_pixel_store
  import rps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rps_req_if.sink               cmd_i,
  rps_rsp_if.source             rsp_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned MW    = WW + HW;

  // Configuration registers
  logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_SIZE_RST;
      frame_height_q <= FRAME_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = WW'(1);
    end else if (SIZE_CMP_W'(frame_width_q) > SIZE_CMP_W'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = HW'(1);
    end else if (SIZE_CMP_W'(frame_height_q) > SIZE_CMP_W'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height_q);
    end
  end

  // Bounds check on the incoming coordinates
  logic in_frame;
  assign in_frame = !cmd_i.pos_x[POS_W-1] && !cmd_i.pos_y[POS_W-1]
                 && ({1'b0, cmd_i.pos_x[POS_W-2:0]} < SIZE_CMP_W'(width_eff))
                 && ({1'b0, cmd_i.pos_y[POS_W-2:0]} < SIZE_CMP_W'(height_eff));

  rps_state_e state_q, state_d;

  rps_cmd_e           cmd_q;
  logic [XW-1:0]      x_q;
  logic [YW-1:0]      y_q;
  logic [PIXEL_W-1:0] pix_q;
  logic               inside_q;
  logic [AW:0]        prod_q;
  logic [AW-1:0]      fill_idx_q, fill_last_q;

  logic               rsp_valid_q;
  logic [COLOR_W-1:0] rsp_color_q;
  logic               rsp_range_q;

  logic               accept;
  logic               rsp_free;
  logic               rsp_load;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [PIXEL_W-1:0] mem_rdata_q;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  // Shared multiplier: y * width for an access, height * width for a fill
  logic [HW-1:0] mul_b;
  logic [MW-1:0] mul_full;
  assign mul_b    = (cmd_q == CMD_FILL) ? height_eff : HW'(y_q);
  assign mul_full = MW'(width_eff) * MW'(mul_b);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACCESS;
      ST_ACCESS: begin
        unique case (cmd_q)
          CMD_READ: state_d = inside_q ? ST_READ : ST_DONE;
          CMD_FILL: state_d = ST_FILL;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_READ: state_d = ST_DONE;
      ST_FILL: begin
        if (fill_idx_q == fill_last_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = AW'(x_q) + prod_q[AW-1:0];
    rsp_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_i.ready = 1'b1;
      ST_ACCESS: begin
        mem_we = (cmd_q == CMD_WRITE) && inside_q;
        mem_re = (cmd_q == CMD_READ) && inside_q;
      end
      ST_FILL: begin
        mem_we   = 1'b1;
        mem_addr = fill_idx_q;
      end
      ST_DONE: rsp_load = rsp_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-command working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= rps_cmd_e'(cmd_i.command);
      x_q      <= cmd_i.pos_x[XW-1:0];
      y_q      <= cmd_i.pos_y[YW-1:0];
      pix_q    <= pack332(cmd_i.color_in);
      inside_q <= in_frame;
    end
    if (state_q == ST_MUL) begin
      prod_q <= (AW+1)'(mul_full);
    end
    if (state_q == ST_ACCESS) begin
      fill_idx_q  <= '0;
      fill_last_q <= AW'(prod_q - (AW+1)'(1));
    end else if (state_q == ST_FILL) begin
      fill_idx_q <= fill_idx_q + AW'(1);
    end
  end

  // Pixel RAM, one port, registered read
  logic [PIXEL_W-1:0] pix_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= pix_q;
    end
    if (mem_re) begin
      mem_rdata_q <= pix_mem[mem_addr];
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_color_q <= ((cmd_q == CMD_READ) && inside_q) ? expand565(mem_rdata_q) : '0;
      rsp_range_q <= (cmd_q == CMD_FILL)
                  || (inside_q && ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)));
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.color_out = rsp_color_q;
  assign rsp_o.in_range  = rsp_range_q;

  // A new response only appears after the sequencer finished a command
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("response raised outside completion");

  // A fill never runs past the last pixel in use
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (fill_idx_q <= fill_last_q))
    else $error("fill index beyond frame");

  // A nonzero color only comes from an in-range read
  a_color_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_color_q != '0)) |-> rsp_range_q)
    else $error("color returned for out-of-range access");

  // A transfer always starts the address step in the next cycle
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MUL))
    else $error("command transfer not followed by address step");

endmodule

[tb/tb_rgb332_pixel_store.sv]
`timescale 1ns / 1ps
module tb_rgb332_pixel_store;
  import rps_pkg::*;

  localparam int unsigned MEM_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned FILL_MAX_PX = 1024;  // random fills only on small frames
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               in_range;
  } px_rsp_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    bit                 fixed;
    logic [COLOR_W-1:0] exp_color;
    logic               exp_rng;
  } dir_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] w_reg;
    logic [CFG_DATA_W-1:0] h_reg;
    int                    n;
    idle_mode_e            mode;
    bit                    pause;
    bit                    hold;
  } phase_t;

  // Rows with fixed=0 take their expected response from the pixel model
  dir_row_t dir_rows [21] = '{
    '{CMD_WRITE,  12'd0,   12'd0,   16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,   12'd0,   12'd0,   16'h0000, 1'b1, 16'hFFFF, 1'b1},
    '{CMD_WRITE,  12'd255, 12'd255, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,   12'd255, 12'd255, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{CMD_WRITE,  12'd256, 12'd0,   16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{CMD_WRITE,  12'd0,   12'd256, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{CMD_WRITE,  12'hFFF, 12'd0,   16'h1234, 1'b1, 16'h0000, 1'b0},
    '{CMD_READ,   12'h800, 12'd0,   16'h0000, 1'b1, 16'h0000, 1'b0},
    '{CMD_READ,   12'h7FF, 12'h7FF, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{CMD_READ,   12'd0,   12'hFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{CMD_UNUSED, 12'd0,   12'd0,   16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{CMD_WRITE,  12'd1,   12'd0,   16'hA5A5, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,   12'd1,   12'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,  12'd2,   12'd0,   16'h5A5A, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,   12'd2,   12'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_FILL,   12'h7FF, 12'h800, 16'h1234, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,   12'd255, 12'd255, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_READ,   12'd100, 12'd17,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_READ,   12'd0,   12'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,  12'h800, 12'h800, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{CMD_UNUSED, 12'h7FF, 12'h7FF, 16'hFFFF, 1'b1, 16'h0000, 1'b0}
  };

  // Sizes 0 and above the maximum exercise the saturation of the frame size
  phase_t phases [10] = '{
    '{9'd1,   9'd1,   60,  IDLE_NONE, 1'b0, 1'b0},
    '{9'd0,   9'd0,   40,  IDLE_SEND, 1'b0, 1'b0},
    '{9'd256, 9'd1,   80,  IDLE_RECV, 1'b0, 1'b0},
    '{9'd1,   9'd256, 80,  IDLE_BOTH, 1'b0, 1'b0},
    '{9'd16,  9'd8,   150, IDLE_SEND, 1'b1, 1'b0},
    '{9'd511, 9'd511, 120, IDLE_RECV, 1'b0, 1'b0},
    '{9'd37,  9'd5,   150, IDLE_BOTH, 1'b0, 1'b0},
    '{9'd8,   9'd8,   120, IDLE_NONE, 1'b0, 1'b1},
    '{9'd256, 9'd256, 100, IDLE_SEND, 1'b0, 1'b0},
    '{9'd300, 9'd3,   100, IDLE_RECV, 1'b1, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rps_req_if cmd_if ();
  rps_rsp_if rsp_if ();

  rgb332_pixel_store u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .cmd_i      (cmd_if),
    .rsp_o      (rsp_if)
  );

  // Pixel model state
  logic [PIXEL_W-1:0]    frame_mem [MEM_DEPTH];
  bit                    frame_mem_set [MEM_DEPTH];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int                    frame_w;
  int                    frame_h;

  px_rsp_t     pixel_rsp_q [$];
  int unsigned err_cnt;
  int unsigned cycles;
  int          send_pct;
  int          recv_pct;
  bit          hold_req;
  int          hold_left;
  int          last_wx;
  int          last_wy;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    err_cnt++;
  endtask

  function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic logic [PIXEL_W-1:0] to_rgb332(input logic [COLOR_W-1:0] c);
    return PIXEL_W'(((c >> 8) & 16'h00E0) | ((c >> 6) & 16'h001C) | ((c >> 3) & 16'h0003));
  endfunction

  function automatic logic [COLOR_W-1:0] to_rgb565(input logic [PIXEL_W-1:0] p);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = {p[7:5], 2'b00};
    g6 = {p[4:2], 3'b000};
    b5 = {p[1:0], 3'b000};
    if (p[5]) r5 = r5 | 5'b00011;
    if (p[2]) g6 = g6 | 6'b000111;
    if (p[0]) b5 = b5 | 5'b00111;
    return {r5, g6, b5};
  endfunction

  function automatic px_rsp_t pixel_store_op(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] px,
                                             input logic [POS_W-1:0] py,
                                             input logic [COLOR_W-1:0] color);
    int      x;
    int      y;
    int      addr;
    bit      hit;
    px_rsp_t r;
    x    = $signed(px);
    y    = $signed(py);
    hit  = x >= 0 && y >= 0 && x < frame_w && y < frame_h;
    addr = hit ? x + y * frame_w : 0;
    r    = '0;
    case (cmd)
      CMD_WRITE: begin
        if (hit) begin
          frame_mem[addr]     = to_rgb332(color);
          frame_mem_set[addr] = 1'b1;
        end
        r.in_range = hit;
      end
      CMD_READ: begin
        if (hit) begin
          r.color    = to_rgb565(frame_mem[addr]);
          r.in_range = 1'b1;
        end
      end
      CMD_FILL: begin
        for (int i = 0; i < frame_w * frame_h; i++) begin
          frame_mem[i]     = to_rgb332(color);
          frame_mem_set[i] = 1'b1;
        end
        r.in_range = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic draw_cmd(output logic [CMD_W-1:0] cmd, output logic [POS_W-1:0] px,
                          output logic [POS_W-1:0] py, output logic [COLOR_W-1:0] color);
    int sel;
    int x;
    int y;
    sel = $urandom_range(99);
    if (sel < 42) cmd = CMD_WRITE;
    else if (sel < 82) cmd = CMD_READ;
    else if (sel < 86) cmd = CMD_UNUSED;
    else if (sel < 89 && frame_w * frame_h <= FILL_MAX_PX) cmd = CMD_FILL;
    else cmd = CMD_WRITE;
    x = $urandom_range(frame_w - 1);
    y = $urandom_range(frame_h - 1);
    case ($urandom_range(9))
      0: begin
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end
      1: x = frame_w;
      2: y = frame_h;
      3: if ($urandom_range(1)) x = -1; else y = -1;
      4: begin
        x = $urandom_range(1) ? frame_w - 1 : 0;
        y = $urandom_range(1) ? frame_h - 1 : 0;
      end
      5: begin
        x = last_wx;
        y = last_wy;
      end
      default: ;
    endcase
    px = x[POS_W-1:0];
    py = y[POS_W-1:0];
    x  = $signed(px);
    y  = $signed(py);
    case ($urandom_range(7))
      0: color = '0;
      1: color = '1;
      default: color = COLOR_W'($urandom_range(65535));
    endcase
    // never read a pixel that holds no data yet; write it instead
    if (cmd == CMD_READ && x >= 0 && y >= 0 && x < frame_w && y < frame_h &&
        !frame_mem_set[x + y * frame_w]) cmd = CMD_WRITE;
    if (cmd == CMD_WRITE) begin
      last_wx = x;
      last_wy = y;
    end
  endtask

  // Returns at the rising edge where the command transfer takes place
  task automatic offer_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [COLOR_W-1:0] color);
    bit took;
    while ($urandom_range(99) < send_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.pos_x    <= px;
    cmd_if.pos_y    <= py;
    cmd_if.color_in <= color;
    do begin
      @(negedge clk);
      took = cmd_if.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic wait_drained();
    while (pixel_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
    frame_w    = clamp_size(width_reg, MAX_WIDTH_DEF);
    frame_h    = clamp_size(height_reg, MAX_HEIGHT_DEF);
  endtask

  // Response side: ready pattern, plus the long hold-off requested by the sender
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  always @(negedge clk) begin : rsp_check
    px_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pixel_rsp_q.size() == 0) begin
        flag_error($sformatf("response with none pending: color_out 0x%04h in_range %0b",
                             rsp_if.color_out, rsp_if.in_range));
      end else begin
        want = pixel_rsp_q.pop_front();
        if (rsp_if.color_out !== want.color)
          flag_error($sformatf("color_out 0x%04h, want 0x%04h", rsp_if.color_out, want.color));
        if (rsp_if.in_range !== want.in_range)
          flag_error($sformatf("in_range %0b, want %0b", rsp_if.in_range, want.in_range));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses pending", cycles, pixel_rsp_q.size());
    $display("FAIL rgb332_pixel_store");
    $finish;
  end

  initial begin
    px_rsp_t            want;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [COLOR_W-1:0] color;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= '0;
    cmd_if.pos_x    <= '0;
    cmd_if.pos_y    <= '0;
    cmd_if.color_in <= '0;
    err_cnt    = 0;
    send_pct   = 0;
    recv_pct   = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    last_wx    = 0;
    last_wy    = 0;
    width_reg  = FRAME_SIZE_RST;
    height_reg = FRAME_SIZE_RST;
    frame_w    = clamp_size(width_reg, MAX_WIDTH_DEF);
    frame_h    = clamp_size(height_reg, MAX_HEIGHT_DEF);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_cmd(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].color);
      want = pixel_store_op(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y,
                            dir_rows[i].color);
      if (dir_rows[i].fixed) want = '{dir_rows[i].exp_color, dir_rows[i].exp_rng};
      pixel_rsp_q.push_back(want);
    end
    cmd_if.valid <= 1'b0;

    foreach (phases[p]) begin
      cfg_set(phases[p].w_reg, phases[p].h_reg);
      send_pct = (phases[p].mode == IDLE_SEND) ? 47 : (phases[p].mode == IDLE_BOTH) ? 13 : 0;
      recv_pct = (phases[p].mode == IDLE_RECV) ? 47 : (phases[p].mode == IDLE_BOTH) ? 13 : 0;
      for (int i = 0; i < phases[p].n; i++) begin
        // receiver blocks while commands keep coming, so the input backs up
        if (phases[p].hold && i == phases[p].n / 3) hold_req = 1'b1;
        if (phases[p].pause && i == phases[p].n / 2) begin
          cmd_if.valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        draw_cmd(cmd, px, py, color);
        offer_cmd(cmd, px, py, color);
        pixel_rsp_q.push_back(pixel_store_op(cmd, px, py, color));
      end
      cmd_if.valid <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS rgb332_pixel_store");
    end else begin
      $display("FAIL rgb332_pixel_store");
    end
    $finish;
  end

endmodule
